// ----- design/source_tokenizer_defines.svh -----
// Assertion macros shared by the tokenizer modules.
// Both expect signals named clk and rst in the scope where they are used.
`ifndef SOURCE_TOKENIZER_DEFINES_SVH
`define SOURCE_TOKENIZER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define STOK_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define STOK_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define STOK_ASSERT(name, prop, msg)
`define STOK_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

// ----- design/stok_pkg.sv -----
package stok_pkg;

  localparam int LINE_WIDTH  = 20;
  localparam int MAX_RESULTS = 4;
  localparam int COUNT_WIDTH = $clog2(MAX_RESULTS + 1);
  localparam int IDX_WIDTH   = $clog2(MAX_RESULTS);

  localparam logic [1:0] EV_TEXT  = 2'd0;
  localparam logic [1:0] EV_CLOSE = 2'd1;
  localparam logic [1:0] EV_END   = 2'd2;
  localparam logic [1:0] EV_ERROR = 2'd3;

  localparam logic [2:0] K_IDENT  = 3'd0;
  localparam logic [2:0] K_NUMBER = 3'd1;
  localparam logic [2:0] K_STRING = 3'd2;
  localparam logic [2:0] K_PUNCT  = 3'd3;
  localparam logic [2:0] K_HASH   = 3'd4;
  localparam logic [2:0] K_END    = 3'd5;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
  localparam logic [1:0] ERR_OPEN_STR   = 2'd2;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       has_byte;
    logic       end_of_source;
  } in_t;

  typedef struct packed {
    logic [1:0]            event_res;
    logic [2:0]            token_kind;
    logic [7:0]            text_byte;
    logic [LINE_WIDTH-1:0] token_line;
    logic [1:0]            error_code;
    logic                  last;
  } out_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0]       count;
    out_t [MAX_RESULTS-1:0]       item;
  } batch_t;

endpackage

// ----- design/source_tokenizer.sv -----
// Channel  Signals                      Payload           Moves
// src      src_valid / src_ready        stok_pkg::in_t    one source byte request
// tok      tok_valid / tok_ready        stok_pkg::out_t   one token event request
//
// A request is registered, scanned combinationally, and its zero to four events land in a
// result buffer draining one event per cycle while tok_ready is high, which sets the rate.
// A request's first tok event follows the input register and then the result buffer load.
// Synchronous reset clears the scanner to idle, line one, and empties both stages.
// A stalled tok side holds its event and backs up src after the input register fills.
module source_tokenizer (
  input  logic           clk,
  input  logic           rst,
  input  logic           src_valid,
  output logic           src_ready,
  input  stok_pkg::in_t  src,
  output logic           tok_valid,
  input  logic           tok_ready,
  output stok_pkg::out_t tok
);

  stok_pkg::batch_t batch;
  logic             batch_load;
  logic             load_ok;

  stok_lexer u_lexer (
    .clk        (clk),
    .rst        (rst),
    .src_valid  (src_valid),
    .src_ready  (src_ready),
    .src        (src),
    .load_ok    (load_ok),
    .batch      (batch),
    .batch_load (batch_load)
  );

  stok_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .batch      (batch),
    .batch_load (batch_load),
    .load_ok    (load_ok),
    .tok_valid  (tok_valid),
    .tok_ready  (tok_ready),
    .tok        (tok)
  );

endmodule

// ----- design/stok_lexer.sv -----
`include "source_tokenizer_defines.svh"

module stok_lexer (
  input  logic            clk,
  input  logic            rst,
  input  logic            src_valid,
  output logic            src_ready,
  input  stok_pkg::in_t   src,
  input  logic            load_ok,
  output stok_pkg::batch_t batch,
  output logic            batch_load
);

  typedef enum logic [2:0] {
    M_IDLE,
    M_IDENT,
    M_NUMBER,
    M_STRING,
    M_STR_ESC,
    M_COLON,
    M_COMMENT,
    M_HALTED
  } mode_t;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;

  localparam logic [stok_pkg::LINE_WIDTH-1:0] LINE_ONE = stok_pkg::LINE_WIDTH'(1);
  localparam logic [stok_pkg::LINE_WIDTH-1:0] LINE_TOP = '1;

  mode_t                             mode;
  mode_t                             mode_next;
  logic [stok_pkg::LINE_WIDTH-1:0]   line_count;
  logic [stok_pkg::LINE_WIDTH-1:0]   line_next;
  logic [stok_pkg::LINE_WIDTH-1:0]   start_line;
  logic [stok_pkg::LINE_WIDTH-1:0]   start_next;
  logic                              in_valid_q;
  stok_pkg::in_t                     in_q;
  logic                              advance;
  logic                              redo;
  logic [7:0]                        c;
  logic [7:0]                        esc;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    return is_alpha(b) || is_digit(b) || (b == CH_UNDER);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  function automatic logic is_punct(input logic [7:0] b);
    case (b)
      8'h7B, 8'h7D, 8'h28, 8'h29, 8'h3B, 8'h2E,
      8'h2C, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3D: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [stok_pkg::LINE_WIDTH-1:0] line_inc(
    input logic [stok_pkg::LINE_WIDTH-1:0] l
  );
    return (l == LINE_TOP) ? l : l + LINE_ONE;
  endfunction

  function automatic stok_pkg::batch_t push(
    input stok_pkg::batch_t                b,
    input logic [1:0]                      ev,
    input logic [2:0]                      kind,
    input logic [7:0]                      tb,
    input logic [stok_pkg::LINE_WIDTH-1:0] line,
    input logic [1:0]                      err
  );
    stok_pkg::batch_t r;
    r = b;
    r.item[b.count[stok_pkg::IDX_WIDTH-1:0]] = '{
      event_res: ev, token_kind: kind, text_byte: tb,
      token_line: line, error_code: err, last: 1'b0
    };
    r.count = b.count + stok_pkg::COUNT_WIDTH'(1);
    return r;
  endfunction

  assign advance    = in_valid_q && (load_ok || (batch.count == '0));
  assign src_ready  = !in_valid_q || advance;
  assign batch_load = advance && (batch.count != '0);
  assign c          = in_q.source_byte;
  assign esc        = (c == CH_N) ? CH_NL : ((c == CH_T) ? CH_TAB : c);

  always_comb begin
    mode_next  = mode;
    line_next  = line_count;
    start_next = start_line;
    batch      = '0;
    redo       = 1'b0;
    if (in_valid_q && (mode != M_HALTED)) begin
      if (in_q.has_byte) begin
        case (mode)
          M_IDENT: begin
            if (is_word(c)) begin
              batch = push(batch, stok_pkg::EV_TEXT, stok_pkg::K_IDENT, c, start_line,
                           stok_pkg::ERR_NONE);
            end else begin
              batch = push(batch, stok_pkg::EV_CLOSE, stok_pkg::K_IDENT, 8'h00, start_line,
                           stok_pkg::ERR_NONE);
              mode_next = M_IDLE;
              redo      = 1'b1;
            end
          end
          M_NUMBER: begin
            if (is_digit(c)) begin
              batch = push(batch, stok_pkg::EV_TEXT, stok_pkg::K_NUMBER, c, start_line,
                           stok_pkg::ERR_NONE);
            end else begin
              batch = push(batch, stok_pkg::EV_CLOSE, stok_pkg::K_NUMBER, 8'h00, start_line,
                           stok_pkg::ERR_NONE);
              mode_next = M_IDLE;
              redo      = 1'b1;
            end
          end
          M_COLON: begin
            mode_next = M_IDLE;
            if (c == CH_COLON) begin
              batch = push(batch, stok_pkg::EV_TEXT, stok_pkg::K_PUNCT, c, start_line,
                           stok_pkg::ERR_NONE);
              batch = push(batch, stok_pkg::EV_CLOSE, stok_pkg::K_PUNCT, 8'h00, start_line,
                           stok_pkg::ERR_NONE);
            end else begin
              batch = push(batch, stok_pkg::EV_CLOSE, stok_pkg::K_PUNCT, 8'h00, start_line,
                           stok_pkg::ERR_NONE);
              redo = 1'b1;
            end
          end
          M_STRING: begin
            if (c == CH_QUOTE) begin
              batch = push(batch, stok_pkg::EV_CLOSE, stok_pkg::K_STRING, 8'h00, start_line,
                           stok_pkg::ERR_NONE);
              mode_next = M_IDLE;
            end else if (c == CH_BSLASH) begin
              mode_next = M_STR_ESC;
            end else begin
              if (c == CH_NL) begin
                line_next = line_inc(line_count);
              end
              batch = push(batch, stok_pkg::EV_TEXT, stok_pkg::K_STRING, c, start_line,
                           stok_pkg::ERR_NONE);
            end
          end
          M_STR_ESC: begin
            batch = push(batch, stok_pkg::EV_TEXT, stok_pkg::K_STRING, esc, start_line,
                         stok_pkg::ERR_NONE);
            mode_next = M_STRING;
          end
          M_COMMENT: begin
            if (c == CH_NL) begin
              line_next = line_inc(line_count);
              mode_next = M_IDLE;
            end
          end
          M_IDLE: begin
            redo = 1'b1;
          end
          default: begin
          end
        endcase

        if (redo) begin
          if (c == CH_NL) begin
            line_next = line_inc(line_count);
          end else if (is_space(c)) begin
            mode_next = M_IDLE;
          end else if (c == CH_AT) begin
            mode_next = M_COMMENT;
          end else if (c == CH_QUOTE) begin
            start_next = line_count;
            mode_next  = M_STRING;
          end else if (c == CH_HASH) begin
            batch = push(batch, stok_pkg::EV_TEXT, stok_pkg::K_HASH, c, line_count,
                         stok_pkg::ERR_NONE);
            batch = push(batch, stok_pkg::EV_CLOSE, stok_pkg::K_HASH, 8'h00, line_count,
                         stok_pkg::ERR_NONE);
          end else if (is_digit(c)) begin
            start_next = line_count;
            mode_next  = M_NUMBER;
            batch = push(batch, stok_pkg::EV_TEXT, stok_pkg::K_NUMBER, c, line_count,
                         stok_pkg::ERR_NONE);
          end else if (is_alpha(c) || (c == CH_UNDER)) begin
            start_next = line_count;
            mode_next  = M_IDENT;
            batch = push(batch, stok_pkg::EV_TEXT, stok_pkg::K_IDENT, c, line_count,
                         stok_pkg::ERR_NONE);
          end else if (c == CH_COLON) begin
            start_next = line_count;
            mode_next  = M_COLON;
            batch = push(batch, stok_pkg::EV_TEXT, stok_pkg::K_PUNCT, c, line_count,
                         stok_pkg::ERR_NONE);
          end else if (is_punct(c)) begin
            batch = push(batch, stok_pkg::EV_TEXT, stok_pkg::K_PUNCT, c, line_count,
                         stok_pkg::ERR_NONE);
            batch = push(batch, stok_pkg::EV_CLOSE, stok_pkg::K_PUNCT, 8'h00, line_count,
                         stok_pkg::ERR_NONE);
          end else begin
            batch = push(batch, stok_pkg::EV_ERROR, stok_pkg::K_IDENT, c, line_count,
                         stok_pkg::ERR_UNEXPECTED);
            mode_next = M_HALTED;
          end
        end
      end

      if (in_q.end_of_source && (mode_next != M_HALTED)) begin
        case (mode_next)
          M_IDENT: begin
            batch = push(batch, stok_pkg::EV_CLOSE, stok_pkg::K_IDENT, 8'h00, start_next,
                         stok_pkg::ERR_NONE);
          end
          M_NUMBER: begin
            batch = push(batch, stok_pkg::EV_CLOSE, stok_pkg::K_NUMBER, 8'h00, start_next,
                         stok_pkg::ERR_NONE);
          end
          M_COLON: begin
            batch = push(batch, stok_pkg::EV_CLOSE, stok_pkg::K_PUNCT, 8'h00, start_next,
                         stok_pkg::ERR_NONE);
          end
          M_STRING, M_STR_ESC: begin
            batch = push(batch, stok_pkg::EV_ERROR, stok_pkg::K_IDENT, 8'h00, start_next,
                         stok_pkg::ERR_OPEN_STR);
            mode_next = M_HALTED;
          end
          default: begin
          end
        endcase
        if (mode_next != M_HALTED) begin
          batch = push(batch, stok_pkg::EV_END, stok_pkg::K_END, 8'h00, line_next,
                       stok_pkg::ERR_NONE);
          mode_next  = M_IDLE;
          line_next  = LINE_ONE;
          start_next = LINE_ONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
      mode       <= M_IDLE;
      line_count <= LINE_ONE;
      start_line <= LINE_ONE;
    end else begin
      if (src_ready) begin
        in_valid_q <= src_valid;
      end
      if (advance) begin
        mode       <= mode_next;
        line_count <= line_next;
        start_line <= start_next;
      end
    end
    if (src_ready && src_valid) begin
      in_q <= src;
    end
  end

  `STOK_ASSERT(a_line_nonzero, line_count != '0, "line counter reached zero")
  `STOK_ASSERT(a_start_le_line, start_line <= line_count, "token start line beyond current line")
  `STOK_ASSERT_NEXT(a_halt_sticks, mode == M_HALTED, mode == M_HALTED, "left halt without reset")
  `STOK_ASSERT(a_halt_quiet, (mode == M_HALTED) |-> !batch_load, "results after halt")

endmodule

// ----- design/stok_serializer.sv -----
`include "source_tokenizer_defines.svh"

module stok_serializer (
  input  logic             clk,
  input  logic             rst,
  input  stok_pkg::batch_t batch,
  input  logic             batch_load,
  output logic             load_ok,
  output logic             tok_valid,
  input  logic             tok_ready,
  output stok_pkg::out_t   tok
);

  logic                           valid;
  logic [stok_pkg::IDX_WIDTH-1:0] idx;
  stok_pkg::batch_t               held;
  logic                           last_beat;

  assign last_beat = (stok_pkg::COUNT_WIDTH'(idx) + stok_pkg::COUNT_WIDTH'(1)) == held.count;
  assign load_ok   = !valid || (tok_ready && last_beat);
  assign tok_valid = valid;

  always_comb begin
    tok      = held.item[idx];
    tok.last = last_beat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (batch_load) begin
      valid <= 1'b1;
      idx   <= '0;
    end else if (valid && tok_ready) begin
      if (last_beat) begin
        valid <= 1'b0;
      end else begin
        idx <= idx + stok_pkg::IDX_WIDTH'(1);
      end
    end
    if (batch_load) begin
      held <= batch;
    end
  end

  `STOK_ASSERT(a_count_range, valid |-> (held.count != '0 && held.count <= stok_pkg::MAX_RESULTS), "held batch count out of range")
  `STOK_ASSERT(a_idx_range, valid |-> (stok_pkg::COUNT_WIDTH'(idx) < held.count), "result index past batch")
  `STOK_ASSERT(a_load_safe, batch_load |-> load_ok, "batch loaded over pending results")
  `STOK_ASSERT_NEXT(a_stall_holds, valid && !tok_ready, valid && $stable(idx), "stalled result moved")

endmodule
